>>> src/mlss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving light segment sweeper package
// Status codes, field widths, pipeline structs and the LED count function.
// ----------------------------------------------------------------------------
package mlss_pkg;

    localparam int POS_W   = 24;
    localparam int SHIFT_W = 32;
    localparam int SPEED_W = 16;
    localparam int LED_W   = 16;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] ST_STOP  = 2'd0;
    localparam logic [CMD_W-1:0] ST_FWD   = 2'd1;
    localparam logic [CMD_W-1:0] ST_BWD   = 2'd2;

    localparam logic [1:0] REG_STRIP_LEN = 2'd0;
    localparam logic [1:0] REG_LIT_LEN   = 2'd1;
    localparam logic [1:0] REG_FRAME_PERIOD   = 2'd2;
    localparam logic [1:0] REG_DENSITY   = 2'd3;

    localparam logic [23:0] STRIP_LEN_RST    = 24'd3276800;
    localparam logic [23:0] LIT_LEN_RST      = 24'd655360;
    localparam logic [15:0] FRAME_PERIOD_RST = 16'd1092;
    localparam logic [15:0] DENSITY_RST      = 16'd15360;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SPEED_W-1:0] speed;
        logic [POS_W-1:0]   step;
    } stage_t;

    typedef struct packed {
        logic               direction_refused;
        logic [LED_W-1:0]   fill_count;
        logic [LED_W-1:0]   fill_start;
        logic               fill_backward;
        logic               fill_valid;
        logic [SPEED_W-1:0] speed_out;
        logic [SHIFT_W-1:0] shift_out;
        logic [POS_W-1:0]   tail_out;
        logic [POS_W-1:0]   head_out;
        logic [CMD_W-1:0]   status_out;
    } result_t;

    // Rounds meters times density (Q16.24) half up, adds one and saturates.
    function automatic logic [LED_W-1:0] led_count(input logic [POS_W-1:0] meters,
                                                   input logic [15:0] density);
        logic [39:0] prod;
        logic [17:0] rnd;
        prod = 40'(meters) * 40'(density);
        rnd  = 18'((prod + 40'h0000800000) >> 24) + 18'd1;
        return (rnd > 18'd65535) ? 16'hFFFF : rnd[15:0];
    endfunction

endpackage
`default_nettype wire

>>> src/mlss_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Input stage
// Registers an accepted request and its step, speed times frame period shifted right by eight bits.
// ----------------------------------------------------------------------------
module mlss_in_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           in_command,
    input  wire logic [15:0]          in_speed,
    input  wire logic [15:0]          frame_period,
    input  wire logic                 advance,
    output logic                      stage_valid,
    output mlss_pkg::stage_t          stage_item
);

    logic             valid_reg;
    logic             valid_next;
    mlss_pkg::stage_t item_reg;
    mlss_pkg::stage_t item_next;
    logic [31:0]      prod;

    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb begin
        prod                = 32'(in_speed) * 32'(frame_period);
        item_next.command   = in_command;
        item_next.speed     = in_speed;
        item_next.step      = prod[31:8];
        valid_next          = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

>>> src/mlss_motion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motion update
// Holds the segment state and computes the new state and the result of one
// request, including the LED fill from the positions held before it.
// ----------------------------------------------------------------------------
module mlss_motion (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire mlss_pkg::stage_t     item,
    input  wire logic [23:0]          strip_len,
    input  wire logic [23:0]          lit_len,
    input  wire logic [15:0]          density,
    output mlss_pkg::result_t         result
);

    logic [1:0]  status_reg,   status_next;
    logic [23:0] head_reg,     head_next;
    logic [24:0] unclamp_reg,  unclamp_next;
    logic [23:0] tail_reg,     tail_next;
    logic [31:0] travel_reg,   travel_next;
    logic [15:0] speed_reg,    speed_next;
    logic        refused;
    logic        moving;
    logic [25:0] temp;
    logic [26:0] limit;
    logic [25:0] tail_raw;
    logic [23:0] seg_len;
    logic        fill_on;

    always_comb begin
        moving       = (status_reg == mlss_pkg::ST_FWD) || (status_reg == mlss_pkg::ST_BWD);
        temp         = 26'(unclamp_reg) + 26'(item.step);
        limit        = 27'(lit_len) + 27'(strip_len) - 27'(item.step);
        tail_raw     = temp - 26'(lit_len);
        status_next  = status_reg;
        head_next    = head_reg;
        unclamp_next = unclamp_reg;
        tail_next    = tail_reg;
        travel_next  = travel_reg;
        speed_next   = speed_reg;
        refused      = 1'b0;
        if (!moving) begin
            status_next  = mlss_pkg::ST_STOP;
            head_next    = '0;
            unclamp_next = '0;
            tail_next    = '0;
            travel_next  = '0;
            speed_next   = '0;
            if ((item.command == mlss_pkg::ST_FWD) || (item.command == mlss_pkg::ST_BWD)) begin
                status_next = item.command;
                speed_next  = item.speed;
            end
        end else if (item.command == mlss_pkg::ST_STOP) begin
            status_next  = mlss_pkg::ST_STOP;
            head_next    = '0;
            unclamp_next = '0;
            tail_next    = '0;
            travel_next  = '0;
            speed_next   = '0;
        end else begin
            refused     = (item.command != status_reg);
            speed_next  = item.speed;
            travel_next = travel_reg + 32'(item.step);
            if ($signed({1'b0, temp}) >= $signed(limit)) begin
                status_next  = (status_reg == mlss_pkg::ST_FWD) ? mlss_pkg::ST_BWD
                                                                : mlss_pkg::ST_FWD;
                head_next    = '0;
                unclamp_next = '0;
                tail_next    = '0;
            end else if (temp >= 26'(strip_len)) begin
                unclamp_next = temp[24:0];
                head_next    = strip_len;
                if (temp < 26'(lit_len)) begin
                    tail_next = '0;
                end else if (tail_raw > 26'(strip_len)) begin
                    tail_next = strip_len;
                end else begin
                    tail_next = tail_raw[23:0];
                end
            end else begin
                head_next    = temp[23:0];
                unclamp_next = temp[24:0];
                tail_next    = (temp > 26'(lit_len)) ? tail_raw[23:0] : '0;
            end
        end

        seg_len = (head_reg > tail_reg) ? (head_reg - tail_reg) : '0;
        fill_on = (status_next == mlss_pkg::ST_FWD) || (status_next == mlss_pkg::ST_BWD);

        result.status_out        = status_next;
        result.head_out          = head_next;
        result.tail_out          = tail_next;
        result.shift_out         = travel_next;
        result.speed_out         = speed_next;
        result.fill_valid        = fill_on;
        result.fill_backward     = fill_on && (status_next == mlss_pkg::ST_BWD);
        result.fill_start        = fill_on ? mlss_pkg::led_count(tail_reg, density)
                                           : '0;
        result.fill_count        = fill_on ? mlss_pkg::led_count(seg_len, density)
                                           : '0;
        result.direction_refused = refused;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= mlss_pkg::ST_STOP;
            head_reg    <= '0;
            unclamp_reg <= '0;
            tail_reg    <= '0;
            travel_reg  <= '0;
            speed_reg   <= '0;
        end else if (advance) begin
            status_reg  <= status_next;
            head_reg    <= head_next;
            unclamp_reg <= unclamp_next;
            tail_reg    <= tail_next;
            travel_reg  <= travel_next;
            speed_reg   <= speed_next;
        end
    end

endmodule
`default_nettype wire

>>> src/moving_light_segment_sweeper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving light segment sweeper
// An accepted request is registered in the input stage and its result in the
// output register. Throughput: one request per cycle unless m_axis stalls;
// the step multiply sits in the input stage and the motion update after it.
// Reset: synchronous, active low; the segment stops at zero and the
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module moving_light_segment_sweeper (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [23:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command [1:0], speed_cmd [17:2], zero pad [23:18]
    input  wire logic [23:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status_out [1:0], head_out [25:2], tail_out [49:26], shift_out [81:50],
    // speed_out [97:82], fill_valid [98], fill_backward [99],
    // fill_start [115:100], fill_count [131:116], direction_refused [132],
    // zero pad [135:133]
    output logic [135:0]      m_axis_tdata
);

    logic [23:0]       line_reg;
    logic [23:0]       active_reg;
    logic [15:0]       period_reg;
    logic [15:0]       density_reg;
    logic              stage_valid;
    mlss_pkg::stage_t  stage_item;
    logic              advance;
    mlss_pkg::result_t result;
    logic              out_valid_reg;
    logic [135:0]      out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= mlss_pkg::STRIP_LEN_RST;
            active_reg  <= mlss_pkg::LIT_LEN_RST;
            period_reg  <= mlss_pkg::FRAME_PERIOD_RST;
            density_reg <= mlss_pkg::DENSITY_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mlss_pkg::REG_STRIP_LEN:    line_reg    <= cfg_wdata;
                mlss_pkg::REG_LIT_LEN:      active_reg  <= cfg_wdata;
                mlss_pkg::REG_FRAME_PERIOD: period_reg  <= cfg_wdata[15:0];
                mlss_pkg::REG_DENSITY:      density_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign advance = stage_valid && (!out_valid_reg || m_axis_tready);

    mlss_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_command   (s_axis_tdata[1:0]),
        .in_speed     (s_axis_tdata[17:2]),
        .frame_period (period_reg),
        .advance      (advance),
        .stage_valid  (stage_valid),
        .stage_item   (stage_item)
    );

    mlss_motion u_motion (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (stage_item),
        .strip_len (line_reg),
        .lit_len   (active_reg),
        .density   (density_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000, result};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire
